// ===== rtl/core/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    // Result field widths are fixed by the result format
    localparam int OUT_W       = 34;
    localparam int STATUS_W    = 2;
    localparam int OUT_TDATA_W = 104;   // three 34-bit fields, padded to 13 bytes
    localparam int OUT_TUSER_W = STATUS_W;

    typedef enum logic [STATUS_W-1:0] {
        ST_TWO_ROOTS = 2'd0,
        ST_NO_REAL   = 2'd1,
        ST_A_ZERO    = 2'd2
    } status_t;

endpackage

// ===== rtl/core/qrs_disc.sv =====
// ----------------------------------------------------------------------------
// qrs_disc
// Three-stage discriminant front end: capture, products, b*b - 4ac and status.
// ----------------------------------------------------------------------------
module qrs_disc #(
    parameter int COEF_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [COEF_BITS-1:0]          coef_a,
    input  logic [COEF_BITS-1:0]          coef_b,
    input  logic [COEF_BITS-1:0]          coef_c,
    output logic                          out_valid,
    output logic signed [COEF_BITS-1:0]   a_out,
    output logic signed [COEF_BITS-1:0]   b_out,
    output logic signed [2*COEF_BITS+1:0] disc_out,
    output qrs_pkg::status_t              status_out
);
    import qrs_pkg::*;

    localparam int DW = 2*COEF_BITS + 2;

    logic                          v1_reg, v2_reg, v3_reg;
    logic signed [COEF_BITS-1:0]   a1_reg, b1_reg, c1_reg;
    logic signed [COEF_BITS-1:0]   a2_reg, b2_reg, a3_reg, b3_reg;
    logic signed [2*COEF_BITS-1:0] bb2_reg, ac2_reg;
    logic signed [DW-1:0]          disc3_reg, disc_next;
    status_t                       st3_reg, st_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_comb begin
        disc_next = DW'(bb2_reg) - (DW'(ac2_reg) <<< 2);
        if (a2_reg == '0) begin
            st_next = ST_A_ZERO;
        end else if (disc_next[DW-1]) begin
            st_next = ST_NO_REAL;
        end else begin
            st_next = ST_TWO_ROOTS;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg    <= coef_a;
            b1_reg    <= coef_b;
            c1_reg    <= coef_c;
            bb2_reg   <= b1_reg * b1_reg;
            ac2_reg   <= a1_reg * c1_reg;
            a2_reg    <= a1_reg;
            b2_reg    <= b1_reg;
            disc3_reg <= disc_next;
            st3_reg   <= st_next;
            a3_reg    <= a2_reg;
            b3_reg    <= b2_reg;
        end
    end

    assign out_valid  = v3_reg;
    assign a_out      = a3_reg;
    assign b_out      = b3_reg;
    assign disc_out   = disc3_reg;
    assign status_out = st3_reg;

endmodule

// ===== rtl/core/qrs_sqrt.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined restoring square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
    parameter int COEF_BITS = 16,
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [2*COEF_BITS+1:0]              radicand,
    input  logic [SIDE_W-1:0]                   side_in,
    output logic                                out_valid,
    output logic [COEF_BITS+FRAC_BITS:0]        root_out,
    output logic [SIDE_W-1:0]                   side_out
);
    import qrs_pkg::*;

    localparam int R  = COEF_BITS + FRAC_BITS + 1;
    localparam int XW = 2*R;
    localparam int RW = R + 2;

    logic [XW-1:0]     x0;
    logic [XW-1:0]     x_reg    [0:R-1];
    logic [RW-1:0]     rem_reg  [0:R-1];
    logic [R-1:0]      root_reg [0:R-1];
    logic [SIDE_W-1:0] side_reg [0:R-1];
    logic              v_reg    [0:R-1];

    // radicand scaled by 2^(2*FRAC_BITS)
    assign x0 = XW'(radicand) << (2*FRAC_BITS);

    for (genvar k = 0; k < R; k++) begin : g_step
        localparam int I = R - 1 - k;
        logic [XW-1:0]     x_in;
        logic [RW-1:0]     rem_in, rem_sh, trial, rem_next;
        logic [R-1:0]      root_in, root_next;
        logic [SIDE_W-1:0] s_in;
        logic              v_in, ge;

        if (k == 0) begin : g_first
            assign x_in    = x0;
            assign rem_in  = '0;
            assign root_in = '0;
            assign s_in    = side_in;
            assign v_in    = in_valid;
        end else begin : g_rest
            assign x_in    = x_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign s_in    = side_reg[k-1];
            assign v_in    = v_reg[k-1];
        end

        always_comb begin
            rem_sh    = {rem_in[RW-3:0], x_in[2*I+1:2*I]};
            trial     = {root_in, 2'b01};
            ge        = (rem_sh >= trial);
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {root_in[R-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k]    <= x_in;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= s_in;
            end
        end
    end

    assign out_valid = v_reg[R-1];
    assign root_out  = root_reg[R-1];
    assign side_out  = side_reg[R-1];

endmodule

// ===== rtl/core/qrs_div.sv =====
// ----------------------------------------------------------------------------
// qrs_div
// Numerator forming and two-lane pipelined signed division by 2a,
// one quotient bit per stage, truncating toward zero.
// ----------------------------------------------------------------------------
module qrs_div #(
    parameter int COEF_BITS = 16,
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic signed [COEF_BITS-1:0]            coef_a,
    input  logic signed [COEF_BITS-1:0]            coef_b,
    input  logic [COEF_BITS+FRAC_BITS:0]           root_s,
    input  logic [SIDE_W-1:0]                      side_in,
    output logic                                   out_valid,
    output logic signed [COEF_BITS+FRAC_BITS+2:0]  quot_plus,
    output logic signed [COEF_BITS+FRAC_BITS+2:0]  quot_minus,
    output logic [SIDE_W-1:0]                      side_out
);
    import qrs_pkg::*;

    localparam int NW = COEF_BITS + FRAC_BITS + 2;  // signed numerator
    localparam int MW = NW;                         // magnitude / quotient bits
    localparam int DM = COEF_BITS + 1;              // |2a|

    // numerator stage
    logic signed [NW-1:0] nb, np_next, nm_next;
    logic signed [NW-1:0] np1_reg, nm1_reg;
    logic signed [DM-1:0] den1_reg;
    logic [SIDE_W-1:0]    side1_reg, side2_reg;
    logic                 v1_reg, v2_reg;

    // magnitude stage
    logic [MW-1:0]        mag2_reg [0:1];
    logic                 neg2_reg [0:1];
    logic [DM-1:0]        dmag2_reg;

    always_comb begin
        nb      = -(NW'(coef_b) <<< FRAC_BITS);
        np_next = nb + signed'({1'b0, root_s});
        nm_next = nb - signed'({1'b0, root_s});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            np1_reg   <= np_next;
            nm1_reg   <= nm_next;
            // a of zero is flagged by status; divide by 2 to keep lanes defined
            den1_reg  <= (coef_a == '0) ? DM'(2) : {coef_a, 1'b0};
            side1_reg <= side_in;
            mag2_reg[0] <= np1_reg[NW-1] ? MW'(-np1_reg) : MW'(np1_reg);
            mag2_reg[1] <= nm1_reg[NW-1] ? MW'(-nm1_reg) : MW'(nm1_reg);
            neg2_reg[0] <= np1_reg[NW-1] ^ den1_reg[DM-1];
            neg2_reg[1] <= nm1_reg[NW-1] ^ den1_reg[DM-1];
            dmag2_reg   <= den1_reg[DM-1] ? DM'(-den1_reg) : DM'(den1_reg);
            side2_reg   <= side1_reg;
        end
    end

    // restoring division steps
    logic [MW-1:0]     n_reg    [0:MW-1][0:1];
    logic [DM:0]       rem_reg  [0:MW-1][0:1];
    logic [MW-1:0]     q_reg    [0:MW-1][0:1];
    logic              ng_reg   [0:MW-1][0:1];
    logic [DM-1:0]     d_reg    [0:MW-1];
    logic [SIDE_W-1:0] side_reg [0:MW-1];
    logic              v_reg    [0:MW-1];

    for (genvar k = 0; k < MW; k++) begin : g_step
        localparam int J = MW - 1 - k;
        logic [DM-1:0]     d_in;
        logic [SIDE_W-1:0] s_in;
        logic              v_in;

        if (k == 0) begin : g_first
            assign d_in = dmag2_reg;
            assign s_in = side2_reg;
            assign v_in = v2_reg;
        end else begin : g_rest
            assign d_in = d_reg[k-1];
            assign s_in = side_reg[k-1];
            assign v_in = v_reg[k-1];
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [MW-1:0] n_in, q_in, q_next;
            logic [DM:0]   rem_in, rem_sh, rem_next;
            logic          ng_in, ge;

            if (k == 0) begin : g_first
                assign n_in   = mag2_reg[l];
                assign q_in   = '0;
                assign rem_in = '0;
                assign ng_in  = neg2_reg[l];
            end else begin : g_rest
                assign n_in   = n_reg[k-1][l];
                assign q_in   = q_reg[k-1][l];
                assign rem_in = rem_reg[k-1][l];
                assign ng_in  = ng_reg[k-1][l];
            end

            always_comb begin
                rem_sh   = {rem_in[DM-1:0], n_in[J]};
                ge       = (rem_sh >= {1'b0, d_in});
                rem_next = ge ? (rem_sh - {1'b0, d_in}) : rem_sh;
                q_next   = {q_in[MW-2:0], ge};
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    n_reg[k][l]   <= n_in;
                    q_reg[k][l]   <= q_next;
                    rem_reg[k][l] <= rem_next;
                    ng_reg[k][l]  <= ng_in;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[k]    <= d_in;
                side_reg[k] <= s_in;
            end
        end
    end

    assign quot_plus  = ng_reg[MW-1][0] ? -signed'({1'b0, q_reg[MW-1][0]})
                                        :  signed'({1'b0, q_reg[MW-1][0]});
    assign quot_minus = ng_reg[MW-1][1] ? -signed'({1'b0, q_reg[MW-1][1]})
                                        :  signed'({1'b0, q_reg[MW-1][1]});
    assign out_valid  = v_reg[MW-1];
    assign side_out   = side_reg[MW-1];

endmodule

// ===== rtl/core/quadratic_root_solver_unit.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit
// Streaming solver for a*x^2 + b*x + c = 0: discriminant, status, two roots.
// ----------------------------------------------------------------------------
// Usage: one coefficient beat may enter every clock while s_axis_tready is
// high; each beat yields exactly one result beat, in order. The pipe holds
// three front-end stages (capture, the two products, the discriminant), one
// stage per root bit of the square root (COEF_BITS+FRAC_BITS+1), two stages to
// form the numerators and their magnitudes, one stage per quotient bit of the
// two-lane divider (COEF_BITS+FRAC_BITS+2), and the output register. The
// whole pipe advances together while the output register is empty or being
// taken, so s_axis_tready drops only when a result is held by back-pressure.
// Status 0 gives both roots in signed fixed point with FRAC_BITS fraction bits,
// truncated toward zero; status 1 (negative discriminant) and status 2 (a is
// zero, which wins) give zero roots. The discriminant is always reported.
// ----------------------------------------------------------------------------
module quadratic_root_solver_unit #(
    parameter int COEF_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // s_axis_tdata: coef_a, coef_b, coef_c (COEF_BITS each), zero pad to bytes
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((3*COEF_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // m_axis_tdata: disc_value[33:0], root_plus[67:34], root_minus[101:68], pad
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [qrs_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // m_axis_tuser: solve_status[1:0]
    output logic [qrs_pkg::OUT_TUSER_W-1:0]      m_axis_tuser
);
    import qrs_pkg::*;

    localparam int DW     = 2*COEF_BITS + 2;
    localparam int R      = COEF_BITS + FRAC_BITS + 1;
    localparam int QW     = COEF_BITS + FRAC_BITS + 3;
    localparam int SQ_SW  = 2*COEF_BITS + STATUS_W + DW;  // a, b, status, disc
    localparam int DV_SW  = STATUS_W + DW;                // status, disc

    logic                          en;
    logic                          m_valid_reg;
    logic [OUT_TDATA_W-1:0]        m_data_reg;
    logic [OUT_TUSER_W-1:0]        m_user_reg;

    // front end
    logic                          d_valid;
    logic signed [COEF_BITS-1:0]   d_a, d_b;
    logic signed [DW-1:0]          d_disc;
    status_t                       d_status;

    // square root
    logic                          s_valid;
    logic [R-1:0]                  s_root;
    logic [SQ_SW-1:0]              s_side;

    // divider
    logic                          q_valid;
    logic signed [QW-1:0]          q_plus, q_minus;
    logic [DV_SW-1:0]              q_side;
    status_t                       q_status;
    logic signed [DW-1:0]          q_disc;
    logic signed [OUT_W-1:0]       rp, rm;

    // global pipe advance: output slot free or being drained
    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    qrs_disc #(
        .COEF_BITS (COEF_BITS)
    ) u_disc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_axis_tvalid),
        .coef_a     (s_axis_tdata[COEF_BITS-1:0]),
        .coef_b     (s_axis_tdata[2*COEF_BITS-1:COEF_BITS]),
        .coef_c     (s_axis_tdata[3*COEF_BITS-1:2*COEF_BITS]),
        .out_valid  (d_valid),
        .a_out      (d_a),
        .b_out      (d_b),
        .disc_out   (d_disc),
        .status_out (d_status)
    );

    // only a valid two-root case feeds a real radicand
    qrs_sqrt #(
        .COEF_BITS (COEF_BITS),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SQ_SW)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid),
        .radicand  ((d_status == ST_TWO_ROOTS) ? DW'(d_disc) : '0),
        .side_in   ({d_a, d_b, d_status, d_disc}),
        .out_valid (s_valid),
        .root_out  (s_root),
        .side_out  (s_side)
    );

    qrs_div #(
        .COEF_BITS (COEF_BITS),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (DV_SW)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_valid),
        .coef_a     (s_side[SQ_SW-1 -: COEF_BITS]),
        .coef_b     (s_side[SQ_SW-COEF_BITS-1 -: COEF_BITS]),
        .root_s     (s_root),
        .side_in    (s_side[DV_SW-1:0]),
        .out_valid  (q_valid),
        .quot_plus  (q_plus),
        .quot_minus (q_minus),
        .side_out   (q_side)
    );

    assign q_status = status_t'(q_side[DV_SW-1 -: STATUS_W]);
    assign q_disc   = q_side[DW-1:0];
    assign rp       = (q_status == ST_TWO_ROOTS) ? OUT_W'(q_plus)  : '0;
    assign rm       = (q_status == ST_TWO_ROOTS) ? OUT_W'(q_minus) : '0;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= OUT_TDATA_W'({rm, rp, OUT_W'(q_disc)});
            m_user_reg <= q_status;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

// ===== rtl/core/qrs_checker.sv =====
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks on the solver's result stream and input stall, bound to the top level.
// ----------------------------------------------------------------------------
module qrs_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [qrs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [qrs_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import qrs_pkg::*;

    // held result beat keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // unused status code never appears
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("status code 3 produced");

    // roots are zero unless two real roots
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser != ST_TWO_ROOTS |->
            m_axis_tdata[3*OUT_W-1:OUT_W] == '0)
        else $error("non-zero roots with failing status");

    // input side stalls together with a held result
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while pipe stalled");

endmodule

bind quadratic_root_solver_unit qrs_checker u_qrs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for quadratic_root_solver_unit: random and directed
// coefficient beats, with results predicted in the bench and compared in order.
// ----------------------------------------------------------------------------
module testbench;
    import qrs_pkg::*;

    localparam int COEF_W    = 16;
    localparam int FRAC_W    = 16;
    localparam int IN_W      = ((3*COEF_W+7)/8)*8;
    localparam int LATENCY   = 2*COEF_W + 2*FRAC_W + 9;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 800;

    typedef struct packed {
        logic [OUT_W-1:0] disc;
        status_t          status;
        logic [OUT_W-1:0] rplus;
        logic [OUT_W-1:0] rminus;
    } solution_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_W-1:0]        s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    logic [IN_W-1:0] coef_queue[$];
    solution_t       solution_queue[$];
    int              n_errors;
    int              idle_cycles;
    bit              stim_done;
    bit              calm;          // stretch with no idling on either side

    quadratic_root_solver_unit #(.COEF_BITS(COEF_W), .FRAC_BITS(FRAC_W)) i_dut (
        .aclk, .aresetn,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // floor(sqrt(d * 2^(2*FRAC_W))), bit by bit over the widened radicand
    function automatic longint unsigned fixed_root(longint unsigned d);
        logic [127:0] rad;
        logic [127:0] res;
        logic [127:0] bitv;
        rad  = 128'(d) << (2*FRAC_W);
        res  = '0;
        bitv = 128'd1 << 126;
        while (bitv > rad) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rad >= res + bitv) begin
                rad = rad - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(res[63:0]);
    endfunction

    function automatic solution_t solve_quadratic(logic [IN_W-1:0] beat);
        solution_t sol;
        longint a, b, c, disc, sq, nb, den, rp, rm;
        a = longint'($signed(beat[COEF_W-1:0]));
        b = longint'($signed(beat[2*COEF_W-1:COEF_W]));
        c = longint'($signed(beat[3*COEF_W-1:2*COEF_W]));
        disc = b*b - 4*a*c;
        rp = 0;
        rm = 0;
        if (a == 0) begin
            sol.status = ST_A_ZERO;
        end else if (disc < 0) begin
            sol.status = ST_NO_REAL;
        end else begin
            sol.status = ST_TWO_ROOTS;
            sq  = longint'(fixed_root(longint'(disc)));
            nb  = -(b <<< FRAC_W);
            den = 2*a;
            rp  = (nb + sq) / den;   // SV division truncates toward zero
            rm  = (nb - sq) / den;
        end
        sol.disc   = disc[OUT_W-1:0];
        sol.rplus  = rp[OUT_W-1:0];
        sol.rminus = rm[OUT_W-1:0];
        return sol;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        n_errors++;
    endtask

    function automatic logic [IN_W-1:0] pack_coefs(logic [15:0] a, logic [15:0] b,
                                                   logic [15:0] c);
        return {c, b, a};
    endfunction

    function automatic logic [15:0] random_coef();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 15)) - 16'd8;  // tiny, many zeros
            1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            2: return 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    // stimulus
    initial begin
        logic [15:0] a, b, c;
        // extremes, each status, perfect squares and the degenerate case
        coef_queue.push_back(pack_coefs(16'd1, -16'sd3, 16'd2));       // roots 1, 2
        coef_queue.push_back(pack_coefs(16'd1, 16'd0, 16'd1));         // no real roots
        coef_queue.push_back(pack_coefs(16'd0, 16'd5, 16'd3));         // a zero
        coef_queue.push_back(pack_coefs(16'd0, 16'd0, 16'h7fff));      // a zero, D zero
        coef_queue.push_back(pack_coefs(16'd1, 16'd2, 16'd1));         // double root
        coef_queue.push_back(pack_coefs(16'd0, 16'd0, 16'd0));
        coef_queue.push_back(pack_coefs(16'h8000, 16'h8000, 16'h7fff)); // largest D
        coef_queue.push_back(pack_coefs(16'h8000, 16'h8000, 16'h8000));
        coef_queue.push_back(pack_coefs(16'h7fff, 16'h8000, 16'h7fff)); // large negative D
        coef_queue.push_back(pack_coefs(16'h7fff, 16'h7fff, 16'h8000));
        coef_queue.push_back(pack_coefs(16'h0001, 16'h8000, 16'h0000)); // roots 32768 and 0
        coef_queue.push_back(pack_coefs(16'hffff, 16'h7fff, 16'h0000));
        coef_queue.push_back(pack_coefs(16'hffff, 16'hffff, 16'hffff));
        coef_queue.push_back(pack_coefs(16'h0001, 16'h0001, 16'h0001));
        coef_queue.push_back(pack_coefs(16'h0002, 16'h0000, 16'hfffe)); // irrational-free
        coef_queue.push_back(pack_coefs(16'h0003, 16'h0007, 16'hfffe));
        coef_queue.push_back(pack_coefs(16'hfffd, 16'h0001, 16'h0004));
        for (int i = 0; i < N_RANDOM; i++) begin
            a = random_coef();
            b = random_coef();
            c = random_coef();
            if ($urandom_range(0, 3) == 0) begin
                // give a and c opposite signs so D >= 0 (c of 16'h8000 keeps its sign)
                if (a[15] == c[15]) c = -c;
            end
            coef_queue.push_back(pack_coefs(a, b, c));
        end
        stim_done = 1'b1;
    end

    // reset, then wait for drain and the tail
    initial begin
        aresetn   = 1'b0;
        n_errors  = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        wait (stim_done && coef_queue.size() == 0 && !s_axis_tvalid
              && solution_queue.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (n_errors == 0)
            $display("[quadratic_root_solver_unit] OK");
        else
            $display("[quadratic_root_solver_unit] ERROR");
        $finish;
    end

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        calm          = 1'b0;
        idle_cycles   = 0;
    end

    // driver: one nonblocking write per signal per edge
    always @(posedge aclk) begin
        int cyc;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            cyc = $urandom_range(0, 99);
            calm <= (coef_queue.size() > 300 && coef_queue.size() < 500);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (coef_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 18)) begin
                    s_axis_tdata  <= coef_queue[0];
                    s_axis_tvalid <= 1'b1;
                    solution_queue.push_back(solve_quadratic(coef_queue.pop_front()));
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= calm || cyc >= 18;
        end
    end

    // monitor and watchdog
    always @(posedge aclk) begin
        solution_t want;
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("[quadratic_root_solver_unit] ERROR");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (solution_queue.size() == 0) begin
                    report_mismatch("unexpected beat", 64'(m_axis_tdata), 64'd0);
                end else begin
                    want = solution_queue.pop_front();
                    if (m_axis_tdata[33:0] !== want.disc)
                        report_mismatch("disc_value", 64'(m_axis_tdata[33:0]), 64'(want.disc));
                    if (m_axis_tuser !== want.status)
                        report_mismatch("solve_status", 64'(m_axis_tuser), 64'(want.status));
                    if (m_axis_tdata[67:34] !== want.rplus)
                        report_mismatch("root_plus", 64'(m_axis_tdata[67:34]), 64'(want.rplus));
                    if (m_axis_tdata[101:68] !== want.rminus)
                        report_mismatch("root_minus", 64'(m_axis_tdata[101:68]),
                                        64'(want.rminus));
                end
            end
        end
    end
endmodule
